>>> design/gql_pkg.sv
// Shared types and constants for the glyph quad layout block.
// No dependencies; every other design file but gql_ram imports this package.
package gql_pkg;

    localparam int GLYPH_SLOTS = 128;
    localparam int SLOT_BITS   = $clog2(GLYPH_SLOTS);
    localparam int COUNT_BITS  = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_W     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_H     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_COLS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CHAR = 3'd7;

    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_SPACE   = 8'd32;
    localparam logic [7:0] CODE_TILDE   = 8'd126;

    // bit-serial divider: 17 quotient bits, divisor up to cols * cell size
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;
    localparam int DEN_W     = 13;
    localparam int NUM_W     = 16;

    // floor(2^37 / 125): x / 250 is done as (x >> 1) / 125
    localparam logic [30:0] RECIP_125   = 31'd1099511627;
    localparam int          RECIP_SHIFT = 37;

    typedef struct packed {
        logic signed [9:0] bx;
        logic signed [9:0] by;
        logic [9:0]        adv;
        logic [7:0]        w;
        logic [7:0]        h;
    } t_glyph;

    localparam int GLYPH_W = $bits(t_glyph);

    typedef struct packed {
        logic take;     // character request accepted
        logic wr;       // glyph table write accepted
        logic load;     // metrics valid, start index divide and positions
        logic tex_go;   // start the four texture divides
        logic out_adv;  // corner taken downstream
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic pos_busy;
        logic last;
    } t_sts;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_DIVK = 5'b00100,
        ST_TEX  = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

endpackage

>>> design/glyph_quad_layout_top.sv
// Top level of the glyph quad layout block.
// Uses gql_pkg; instantiates gql_ctrl and gql_dp.

// Glyph writes (func 0) store metrics in a 128-entry table. A character
// request (func 1) first reads the table, then runs the bit-serial divide that
// splits the glyph index into atlas row and column, then the four parallel
// texture-coordinate divides (the position pipeline runs underneath), then
// gives four results, one per quad corner, top left first, each held while the
// output stalls. A new request is taken only once the fourth corner of the
// current one has been delivered. The user is to write configuration through
// the plain write port only while the block is idle; the block does not enforce it.
module glyph_quad_layout_top import gql_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_func,
    input  logic [6:0]            i_glyph_slot,
    input  logic signed [9:0]     i_bearing_x,
    input  logic signed [9:0]     i_bearing_y,
    input  logic [9:0]            i_advance,
    input  logic [7:0]            i_glyph_width,
    input  logic [7:0]            i_glyph_height,
    input  logic [7:0]            i_char_code,
    input  logic                  i_first_of_text,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [17:0]    o_vertex_x,
    output logic signed [17:0]    o_vertex_y,
    output logic [15:0]           o_tex_u,
    output logic [15:0]           o_tex_v,
    output logic [1:0]            o_corner,
    output logic [15:0]           o_vertex_index,
    output logic                  o_last_corner
);

    t_cmd cmd;
    t_sts sts;

    gql_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    gql_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_glyph_slot    (i_glyph_slot),
        .i_bearing_x     (i_bearing_x),
        .i_bearing_y     (i_bearing_y),
        .i_advance       (i_advance),
        .i_glyph_width   (i_glyph_width),
        .i_glyph_height  (i_glyph_height),
        .i_char_code     (i_char_code),
        .i_first_of_text (i_first_of_text),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_vertex_x      (o_vertex_x),
        .o_vertex_y      (o_vertex_y),
        .o_tex_u         (o_tex_u),
        .o_tex_v         (o_tex_v),
        .o_corner        (o_corner),
        .o_vertex_index  (o_vertex_index),
        .o_last_corner   (o_last_corner)
    );

endmodule

>>> design/gql_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/gql_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Computes floor((rem0 * 2^17 + bits) / den) for rem0 < den. Uses gql_pkg.
module gql_div import gql_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DEN_W-1:0]     i_rem0,
    input  logic [DIV_STEPS-1:0] i_bits,
    input  logic [DEN_W-1:0]     i_den,
    output logic                 o_busy,
    output logic [DIV_STEPS-1:0] o_quo,
    output logic [DEN_W-1:0]     o_rem
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [DIV_STEPS-1:0] r_bits;
    logic [DIV_STEPS-1:0] r_quo;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_bits[DIV_STEPS-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem0;
            r_den  <= i_den;
            r_bits <= i_bits;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_bits <= {r_bits[DIV_STEPS-2:0], 1'b0};
            r_quo  <= {r_quo[DIV_STEPS-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

>>> design/gql_ctrl.sv
// Sequencer for the glyph quad layout block: handshakes and phase control.
// Uses gql_pkg; drives commands into gql_dp and reads its status.
module gql_ctrl import gql_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_func,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_func) begin
                        o_cmd.take = 1'b1;
                        n_state    = ST_LOAD;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_DIVK;
            end
            ST_DIVK: begin
                if (!i_sts.div_busy) begin
                    o_cmd.tex_go = 1'b1;
                    n_state      = ST_TEX;
                end
            end
            ST_TEX: begin
                if (!i_sts.div_busy && !i_sts.pos_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.out_adv = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/gql_dp.sv
// Datapath: config registers, pen state, glyph table, position pipeline,
// texture dividers and corner output mux. Uses gql_pkg, gql_ram, gql_div.
module gql_dp import gql_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [6:0]            i_glyph_slot,
    input  logic signed [9:0]     i_bearing_x,
    input  logic signed [9:0]     i_bearing_y,
    input  logic [9:0]            i_advance,
    input  logic [7:0]            i_glyph_width,
    input  logic [7:0]            i_glyph_height,
    input  logic [7:0]            i_char_code,
    input  logic                  i_first_of_text,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic signed [17:0]    o_vertex_x,
    output logic signed [17:0]    o_vertex_y,
    output logic [15:0]           o_tex_u,
    output logic [15:0]           o_tex_v,
    output logic [1:0]            o_corner,
    output logic [15:0]           o_vertex_index,
    output logic                  o_last_corner
);

    // ---------------- configuration ----------------
    logic signed [12:0] r_start_x;
    logic signed [20:0] r_start_y;
    logic [15:0]        r_scale_x;
    logic [15:0]        r_scale_y;
    logic [7:0]         r_cell_w;
    logic [7:0]         r_cell_h;
    logic [4:0]         r_cols;
    logic [6:0]         r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_scale_x <= 16'd4096;
            r_scale_y <= 16'd4096;
            r_cell_w  <= 8'd1;
            r_cell_h  <= 8'd1;
            r_cols    <= 5'd10;
            r_first   <= 7'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_X:    r_start_x <= i_cfg_data[12:0];
                CFG_START_Y:    r_start_y <= i_cfg_data[20:0];
                CFG_SCALE_X:    r_scale_x <= i_cfg_data[15:0];
                CFG_SCALE_Y:    r_scale_y <= i_cfg_data[15:0];
                CFG_CELL_W:     r_cell_w  <= i_cfg_data[7:0];
                CFG_CELL_H:     r_cell_h  <= i_cfg_data[7:0];
                CFG_ATLAS_COLS: r_cols    <= i_cfg_data[4:0];
                CFG_FIRST_CHAR: r_first   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // zero sizes behave as one
    logic [7:0] cw_e;
    logic [7:0] ch_e;
    logic [4:0] cols_e;

    assign cw_e   = (r_cell_w == 8'd0) ? 8'd1 : r_cell_w;
    assign ch_e   = (r_cell_h == 8'd0) ? 8'd1 : r_cell_h;
    assign cols_e = (r_cols == 5'd0) ? 5'd1 : r_cols;

    // ---------------- pen state and request capture ----------------
    logic signed [15:0]   r_pen_x;
    logic signed [23:0]   r_pen_y;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [7:0]           r_k;
    logic                 r_kok;
    logic [1:0]           r_corner;
    logic signed [15:0]   r_pen_nxt;

    logic [7:0]         letter;
    logic [7:0]         k;
    logic signed [15:0] px_a;
    logic signed [23:0] py_a;
    logic signed [24:0] py_nl;
    logic signed [23:0] py_nls;
    logic signed [15:0] px_t;
    logic signed [23:0] py_t;

    always_comb begin
        letter = (i_char_code > CODE_TILDE || i_char_code < CODE_SPACE) ? CODE_SPACE
                                                                      : i_char_code;
        k      = letter - {1'b0, r_first};
        px_a   = i_first_of_text ? 16'(r_start_x) : r_pen_x;
        py_a   = i_first_of_text ? 24'(r_start_y) : r_pen_y;
        py_nl  = 25'(py_a) - $signed({9'b0, ch_e, 8'b0});
        // only the low side can overflow
        py_nls = (py_nl[24] != py_nl[23]) ? 24'sh800000 : py_nl[23:0];
        px_t   = px_a;
        py_t   = py_a;
        if (i_char_code == CODE_NEWLINE) begin
            px_t = 16'(r_start_x);
            py_t = py_nls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= '0;
            r_pen_y  <= '0;
            r_cnt    <= '0;
            r_corner <= '0;
        end else if (i_cmd.take) begin
            r_pen_x  <= px_t;
            r_pen_y  <= py_t;
            r_cnt    <= i_first_of_text ? '0 : r_cnt;
            r_corner <= '0;
        end else if (i_cmd.out_adv) begin
            r_corner <= r_corner + 1'b1;
            if (r_corner == 2'd3) begin
                r_pen_x <= r_pen_nxt;
                r_cnt   <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_k   <= k;
            r_kok <= ({1'b0, k} < 9'(GLYPH_SLOTS));
        end
    end

    // ---------------- glyph table ----------------
    t_glyph ram_wdata;
    t_glyph ram_rdata;
    t_glyph r_g;
    logic   ram_we;

    always_comb begin
        ram_wdata.bx  = i_bearing_x;
        ram_wdata.by  = i_bearing_y;
        ram_wdata.adv = i_advance;
        ram_wdata.w   = i_glyph_width;
        ram_wdata.h   = i_glyph_height;
        ram_we        = i_cmd.wr && ({2'b0, i_glyph_slot} < 9'(GLYPH_SLOTS));
    end

    gql_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (GLYPH_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (SLOT_BITS'(i_glyph_slot)),
        .i_wdata (ram_wdata),
        .i_raddr (k[SLOT_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_g <= r_kok ? ram_rdata : '0;
        end
    end

    // ---------------- next pen x: truncate toward zero ----------------
    logic signed [27:0] adv_p;
    logic signed [28:0] nx;
    logic signed [16:0] nt;
    logic signed [16:0] nt_r;

    always_comb begin
        adv_p = $signed({1'b0, r_g.adv}) * $signed({1'b0, r_scale_x});
        nx    = (29'(r_pen_x) <<< 12) + 29'(adv_p);
        nt    = 17'(nx >>> 12);
        nt_r  = (nx < 0 && nx[11:0] != 12'd0) ? nt + 17'sd1 : nt;
    end

    always_ff @(posedge i_clk) begin
        if (nt_r > 17'sd32767) begin
            r_pen_nxt <= 16'sh7fff;
        end else if (nt_r < -17'sd32768) begin
            r_pen_nxt <= 16'sh8000;
        end else begin
            r_pen_nxt <= nt_r[15:0];
        end
    end

    // ---------------- position pipeline (divide by 250, round) ----------------
    // order: left x, right x, top y, bottom y
    logic               r_prun;
    logic [1:0]         r_pidx;
    logic               r_v1, r_v2, r_v3;
    logic [1:0]         r_i1, r_i2, r_i3;
    logic signed [30:0] r_raw;
    logic [30:0]        r_a2, r_a3;
    logic               r_sg2, r_sg3;
    logic [61:0]        r_prod;
    logic signed [17:0] r_pos [4];

    logic signed [30:0] base;
    logic signed [11:0] off;
    logic [15:0]        scl;
    logic signed [11:0] top_off;
    logic signed [30:0] raw;
    logic [30:0]        mag;
    logic [31:0]        mrd;
    logic [24:0]        q0;
    logic [30:0]        rr;
    logic [24:0]        q;
    logic [24:0]        cap;
    logic [24:0]        qs;

    always_comb begin
        top_off = 12'(r_g.by) - 12'($signed({1'b0, ch_e}));
        case (r_pidx)
            2'd0: begin
                base = 31'(r_pen_x) <<< 12;
                off  = 12'(r_g.bx);
                scl  = r_scale_x;
            end
            2'd1: begin
                base = 31'(r_pen_x) <<< 12;
                off  = 12'(r_g.bx) + 12'($signed({1'b0, r_g.w}));
                scl  = r_scale_x;
            end
            2'd2: begin
                base = 31'(r_pen_y) <<< 4;
                off  = top_off;
                scl  = r_scale_y;
            end
            default: begin
                base = 31'(r_pen_y) <<< 4;
                off  = top_off - 12'($signed({1'b0, r_g.h}));
                scl  = r_scale_y;
            end
        endcase
        raw = base + 31'(off * $signed({1'b0, scl}));

        mag = r_raw[30] ? 31'(-r_raw) : 31'(r_raw);
        mrd = 32'(mag) + 32'd125;

        q0  = r_prod[RECIP_SHIFT +: 25];
        rr  = r_a3 - 31'(q0 * 7'd125);
        q   = (rr >= 31'd125) ? q0 + 25'd1 : q0;
        cap = r_sg3 ? 25'd131072 : 25'd131071;
        qs  = (q > cap) ? cap : q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prun <= 1'b0;
            r_pidx <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_prun <= 1'b1;
                r_pidx <= '0;
            end else if (r_prun) begin
                r_pidx <= r_pidx + 1'b1;
                if (r_pidx == 2'd3) begin
                    r_prun <= 1'b0;
                end
            end
            r_v1 <= r_prun;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw  <= raw;
        r_i1   <= r_pidx;
        r_a2   <= mrd[31:1];
        r_sg2  <= r_raw[30];
        r_i2   <= r_i1;
        r_prod <= r_a2 * RECIP_125;
        r_a3   <= r_a2;
        r_sg3  <= r_sg2;
        r_i3   <= r_i2;
        if (r_v3) begin
            r_pos[r_i3] <= r_sg3 ? -18'(qs) : 18'(qs);
        end
    end

    // ---------------- texture dividers ----------------
    // lane 0 first splits k into row and column, then all lanes form u/v
    logic [DEN_W-1:0]     d_rem0 [4];
    logic [DIV_STEPS-1:0] d_bits [4];
    logic [DEN_W-1:0]     d_den  [4];
    logic                 d_start [4];
    logic                 d_busy [4];
    logic [DIV_STEPS-1:0] d_quo  [4];
    logic [DEN_W-1:0]     d_rem  [4];
    logic [NUM_W-1:0]     t_num  [4];
    logic [DEN_W-1:0]     t_den  [4];
    logic                 t_sat  [4];
    logic [3:0]           r_tsat;
    logic [15:0]          tex    [4];
    logic [4:0]           col;
    logic [7:0]           row;

    always_comb begin
        col      = d_rem[0][4:0];
        row      = d_quo[0][7:0];
        t_num[0] = NUM_W'(col);
        t_den[0] = DEN_W'(cols_e);
        t_num[1] = NUM_W'(col * cw_e) + NUM_W'(r_g.w);
        t_den[1] = DEN_W'(cols_e * cw_e);
        t_num[2] = NUM_W'(row);
        t_den[2] = DEN_W'(cols_e);
        t_num[3] = NUM_W'(row * ch_e) + NUM_W'(r_g.h);
        t_den[3] = DEN_W'(cols_e * ch_e);
        for (int i = 0; i < 4; i++) begin
            t_sat[i]   = (t_num[i] >= NUM_W'(t_den[i]));
            d_rem0[i]  = t_sat[i] ? '0 : t_num[i][DEN_W-1:0];
            d_bits[i]  = '0;
            d_den[i]   = t_den[i];
            d_start[i] = i_cmd.tex_go;
        end
        if (i_cmd.load) begin
            d_rem0[0]  = '0;
            d_bits[0]  = DIV_STEPS'(r_k);
            d_den[0]   = DEN_W'(cols_e);
            d_start[0] = 1'b1;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        logic [DIV_STEPS:0] qp;

        gql_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (d_start[g]),
            .i_rem0  (d_rem0[g]),
            .i_bits  (d_bits[g]),
            .i_den   (d_den[g]),
            .o_busy  (d_busy[g]),
            .o_quo   (d_quo[g]),
            .o_rem   (d_rem[g])
        );

        // round half up: (q + 1) / 2, clamp at full scale
        assign qp     = {1'b0, d_quo[g]} + 1'b1;
        assign tex[g] = (r_tsat[g] || qp[DIV_STEPS]) ? 16'hffff : qp[16:1];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tex_go) begin
            r_tsat <= {t_sat[3], t_sat[2], t_sat[1], t_sat[0]};
        end
    end

    // ---------------- status and corner output ----------------
    logic right;
    logic bottom;

    always_comb begin
        right          = (r_corner == 2'd1) || (r_corner == 2'd2);
        bottom         = r_corner[1];
        o_sts.div_busy = d_busy[0] | d_busy[1] | d_busy[2] | d_busy[3];
        o_sts.pos_busy = r_prun | r_v1 | r_v2 | r_v3;
        o_sts.last     = (r_corner == 2'd3);
        o_vertex_x     = right ? r_pos[1] : r_pos[0];
        o_vertex_y     = bottom ? r_pos[3] : r_pos[2];
        o_tex_u        = right ? tex[1] : tex[0];
        o_tex_v        = bottom ? tex[3] : tex[2];
        o_corner       = r_corner;
        o_vertex_index = (16'(r_cnt) << 2) | 16'(r_corner);
        o_last_corner  = (r_corner == 2'd3);
    end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for glyph_quad_layout_top: random and directed requests,
// with a scoreboard class that predicts the four quad corners of each character.
// Depends on gql_pkg and the design files.
`timescale 1ns / 100ps

module testbench import gql_pkg::*; ();

    localparam int LIMIT_CYCLES = 600000;
    localparam int SETTLE       = 60;

    typedef struct {
        bit              func;
        logic [6:0]      slot;
        logic [9:0]      bx;
        logic [9:0]      by;
        logic [9:0]      adv;
        logic [7:0]      w;
        logic [7:0]      h;
        logic [7:0]      code;
        bit              first;
    } t_req;

    typedef struct {
        logic [17:0] vx;
        logic [17:0] vy;
        logic [15:0] u;
        logic [15:0] v;
        logic [1:0]  corner;
        logic [15:0] vidx;
        logic        last;
    } t_corner;

    class quad_scoreboard;
        t_corner    corners_due[$];
        int         errors;
        longint     g_bx[GLYPH_SLOTS], g_by[GLYPH_SLOTS];
        longint     g_adv[GLYPH_SLOTS], g_w[GLYPH_SLOTS], g_h[GLYPH_SLOTS];
        bit         written[GLYPH_SLOTS];
        longint     pen_x, pen_y, char_cnt;
        longint     start_x, start_y, scale_x, scale_y, cell_w, cell_h, cols, first_char;

        function new();
            errors = 0;
            pen_x = 0; pen_y = 0; char_cnt = 0;
            start_x = 0; start_y = 0; scale_x = 4096; scale_y = 4096;
            cell_w = 1; cell_h = 1; cols = 10; first_char = 32;
            foreach (written[i]) written[i] = 0;
        endfunction

        function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_START_X:    start_x = $signed(val[12:0]);
                CFG_START_Y:    start_y = $signed(val[20:0]);
                CFG_SCALE_X:    scale_x = val[15:0];
                CFG_SCALE_Y:    scale_y = val[15:0];
                CFG_CELL_W:     cell_w = val[7:0];
                CFG_CELL_H:     cell_h = val[7:0];
                CFG_ATLAS_COLS: cols = val[4:0];
                CFG_FIRST_CHAR: first_char = val[6:0];
                default: ;
            endcase
        endfunction

        function longint glyph_index(logic [7:0] code);
            longint letter;
            letter = (code > CODE_TILDE || code < CODE_SPACE) ? CODE_SPACE : code;
            return (letter - first_char) & 255;
        endfunction

        function longint clamp(longint x, longint lo, longint hi);
            return x < lo ? lo : (x > hi ? hi : x);
        endfunction

        function logic [15:0] atlas_coord(longint num, longint den);
            return 16'(clamp((num * 131072 + den) / (2 * den), 0, 65535));
        endfunction

        function logic [17:0] screen_pos(longint q);
            longint r;
            r = q >= 0 ? (q + 125) / 250 : -((-q + 125) / 250);
            return 18'(clamp(r, -131072, 131071));
        endfunction

        function void note_request(t_req r);
            longint k, cw, ch, nc, bx, by, adv, w, h, left, xl, xr, yt, yb, top_off;
            longint col, row;
            logic [15:0] ul, ur, vt, vb;
            t_corner c;
            if (!r.func) begin
                g_bx[r.slot] = $signed(r.bx); g_by[r.slot] = $signed(r.by);
                g_adv[r.slot] = r.adv; g_w[r.slot] = r.w; g_h[r.slot] = r.h;
                written[r.slot] = 1;
                return;
            end
            cw = cell_w ? cell_w : 1;
            ch = cell_h ? cell_h : 1;
            nc = cols ? cols : 1;
            if (r.first) begin
                pen_x = start_x; pen_y = start_y; char_cnt = 0;
            end
            k = glyph_index(r.code);
            if (k < GLYPH_SLOTS) begin
                bx = g_bx[k]; by = g_by[k]; adv = g_adv[k]; w = g_w[k]; h = g_h[k];
            end else begin
                bx = 0; by = 0; adv = 0; w = 0; h = 0;
            end
            if (r.code == CODE_NEWLINE) begin
                pen_x = start_x;
                pen_y = clamp(pen_y - ch * 256, -8388608, 8388607);
            end
            left = pen_x;
            pen_x = clamp((left * 4096 + adv * scale_x) / 4096, -32768, 32767);
            xl = left * 4096 + bx * scale_x;
            xr = left * 4096 + (w + bx) * scale_x;
            top_off = by - ch;
            yt = pen_y * 16 + top_off * scale_y;
            yb = pen_y * 16 + (top_off - h) * scale_y;
            col = k % nc;
            row = k / nc;
            ul = atlas_coord(col, nc);
            ur = atlas_coord(col * cw + w, nc * cw);
            vt = atlas_coord(row, nc);
            vb = atlas_coord(row * ch + h, nc * ch);
            for (int i = 0; i < 4; i++) begin
                c.vx = screen_pos((i == 1 || i == 2) ? xr : xl);
                c.vy = screen_pos(i >= 2 ? yb : yt);
                c.u = (i == 1 || i == 2) ? ur : ul;
                c.v = i >= 2 ? vb : vt;
                c.corner = 2'(i);
                c.vidx = 16'(char_cnt * 4 + i);
                c.last = (i == 3);
                corners_due.push_back(c);
            end
            char_cnt = (char_cnt + 1) % (1 << COUNT_BITS);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_corner(t_corner got);
            t_corner want;
            if (corners_due.size() == 0) begin
                report("unexpected corner, index", got.vidx, 0);
                return;
            end
            want = corners_due.pop_front();
            if (got.vx !== want.vx) report("vertex_x", got.vx, want.vx);
            if (got.vy !== want.vy) report("vertex_y", got.vy, want.vy);
            if (got.u !== want.u) report("tex_u", got.u, want.u);
            if (got.v !== want.v) report("tex_v", got.v, want.v);
            if (got.corner !== want.corner) report("corner", got.corner, want.corner);
            if (got.vidx !== want.vidx) report("vertex_index", got.vidx, want.vidx);
            if (got.last !== want.last) report("last_corner", got.last, want.last);
        endtask
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 0;
    logic                  o_in_stall;
    logic                  i_func = 0;
    logic [6:0]            i_glyph_slot = '0;
    logic signed [9:0]     i_bearing_x = '0;
    logic signed [9:0]     i_bearing_y = '0;
    logic [9:0]            i_advance = '0;
    logic [7:0]            i_glyph_width = '0;
    logic [7:0]            i_glyph_height = '0;
    logic [7:0]            i_char_code = '0;
    logic                  i_first_of_text = 0;
    logic                  o_out_valid;
    logic                  i_out_stall = 0;
    logic signed [17:0]    o_vertex_x;
    logic signed [17:0]    o_vertex_y;
    logic [15:0]           o_tex_u;
    logic [15:0]           o_tex_v;
    logic [1:0]            o_corner;
    logic [15:0]           o_vertex_index;
    logic                  o_last_corner;

    quad_scoreboard sb = new();
    int cycle = 0;

    glyph_quad_layout_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // quiet stretch with no idling on either side
    function bit take_break();
        if (cycle > 9000 && cycle < 13000)
            return 0;
        return $urandom_range(99) < 11;
    endfunction

    // receiver: random stalls plus one long hold-off while requests keep coming
    initial begin
        t_corner got;
        forever begin
            @(negedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                got.vx = o_vertex_x; got.vy = o_vertex_y;
                got.u = o_tex_u; got.v = o_tex_v;
                got.corner = o_corner; got.vidx = o_vertex_index;
                got.last = o_last_corner;
                sb.check_corner(got);
            end
            @(posedge i_clk);
            if (cycle > 5000 && cycle < 5600)
                i_out_stall <= 1;
            else
                i_out_stall <= take_break();
        end
    end

    task send(t_req r);
        bit taken;
        while (take_break()) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_func <= r.func; i_glyph_slot <= r.slot;
        i_bearing_x <= r.bx; i_bearing_y <= r.by; i_advance <= r.adv;
        i_glyph_width <= r.w; i_glyph_height <= r.h;
        i_char_code <= r.code; i_first_of_text <= r.first;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        sb.note_request(r);
    endtask

    function t_req random_req();
        t_req r;
        r.func = 1'($urandom_range(1));
        r.slot = 7'($urandom); r.bx = 10'($urandom); r.by = 10'($urandom);
        r.adv = 10'($urandom); r.w = 8'($urandom); r.h = 8'($urandom);
        r.code = 8'($urandom); r.first = 1'($urandom);
        return r;
    endfunction

    // lay out a character, defining its table slot first where needed
    task send_char(logic [7:0] code, bit first);
        t_req r;
        longint k;
        k = sb.glyph_index(code);
        if (k < GLYPH_SLOTS && !sb.written[k]) begin
            r = random_req();
            r.func = 0; r.slot = 7'(k);
            send(r);
        end
        r = random_req();
        r.func = 1; r.code = code; r.first = first;
        send(r);
    endtask

    task send_glyph(logic [6:0] slot, logic [9:0] bx, logic [9:0] by, logic [9:0] adv,
                    logic [7:0] w, logic [7:0] h);
        t_req r;
        r = random_req();
        r.func = 0; r.slot = slot; r.bx = bx; r.by = by; r.adv = adv; r.w = w; r.h = h;
        send(r);
    endtask

    task wait_drained();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.corners_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_cfg(idx, val);
    endtask

    task setup(int sx, int sy, int scx, int scy, int cw, int ch, int nc, int fc);
        write_cfg(CFG_START_X, CFG_DATA_W'(sx));
        write_cfg(CFG_START_Y, CFG_DATA_W'(sy));
        write_cfg(CFG_SCALE_X, CFG_DATA_W'(scx));
        write_cfg(CFG_SCALE_Y, CFG_DATA_W'(scy));
        write_cfg(CFG_CELL_W, CFG_DATA_W'(cw));
        write_cfg(CFG_CELL_H, CFG_DATA_W'(ch));
        write_cfg(CFG_ATLAS_COLS, CFG_DATA_W'(nc));
        write_cfg(CFG_FIRST_CHAR, CFG_DATA_W'(fc));
        i_cfg_we <= 0;
    endtask

    function logic [7:0] pick_code();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8) return CODE_NEWLINE;
        if (sel < 16) return 8'($urandom_range(255));
        return 8'($urandom_range(CODE_TILDE, CODE_SPACE));
    endfunction

    task random_phase(int count);
        t_req r;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 25) begin
                r = random_req();
                r.func = 0;
                send(r);
            end else begin
                send_char(pick_code(), $urandom_range(99) < 10);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: metric extremes, unprintable codes, newline, text restart
        send_glyph(7'd0, 10'h200, 10'h1FF, 10'h3FF, 8'hFF, 8'hFF);
        send_glyph(7'd94, 10'h1FF, 10'h200, 10'h000, 8'h00, 8'h00);
        send_glyph(7'd1, 10'h000, 10'h000, 10'h155, 8'hAA, 8'h55);
        send_char(CODE_SPACE, 1'b1);
        send_char(8'd0, 1'b0);
        send_char(8'd255, 1'b0);
        send_char(CODE_TILDE, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        send_char(8'd33, 1'b0);
        send_char(8'd31, 1'b0);
        send_char(8'd127, 1'b1);
        send_char(CODE_NEWLINE, 1'b1);
        wait_drained();

        setup(-4096, -1048576, 0, 65535, 255, 255, 16, 0);
        send_char(CODE_SPACE, 1'b1);
        send_char(8'd126, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        send_char(CODE_NEWLINE, 1'b0);
        random_phase(40);
        wait_drained();

        // every letter maps past the table here
        setup(4095, 1048575, 65535, 0, 1, 1, 1, 127);
        send_char(CODE_SPACE, 1'b1);
        send_char(CODE_TILDE, 1'b0);
        random_phase(40);
        wait_drained();

        // zero cell sizes and columns act as one
        setup(0, 0, 4096, 4096, 0, 0, 0, 32);
        random_phase(30);
        wait_drained();

        setup(-100, 5000, 65535, 65535, 255, 255, 31, 20);
        random_phase(45);
        wait_drained();

        for (int p = 0; p < 3; p++) begin
            setup($urandom_range(8191), $urandom_range(2097151), $urandom_range(65535),
                  $urandom_range(65535), $urandom_range(255, 1), $urandom_range(255, 1),
                  $urandom_range(16, 1), $urandom_range(127));
            random_phase(40);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> filelist.f
design/gql_pkg.sv
design/gql_ram.sv
design/gql_div.sv
design/gql_ctrl.sv
design/gql_dp.sv
design/glyph_quad_layout_top.sv
verif/testbench.sv
